>>> hw/rtl/lpar_pkg.sv
// ----------------------------------------------------------------------------
// lpar_pkg
// Shared constants and types for the palindromic-anagram run unit.
// ----------------------------------------------------------------------------
package lpar_pkg;

  localparam int NUM_SYMBOLS = 10;
  localparam int MASK_W      = NUM_SYMBOLS;
  localparam int DIGIT_W     = 4;
  localparam int CNT_W       = 16;
  localparam int MAX_LEN     = 65535;
  localparam int EPOCH_W     = 8;
  localparam int ENT_W       = EPOCH_W + CNT_W;
  localparam int PROBE_N     = NUM_SYMBOLS + 1;
  localparam int PIDX_W      = $clog2(PROBE_N);

  localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);
  localparam logic [EPOCH_W-1:0] EPOCH_LAST  = {EPOCH_W{1'b1}};

  // table entry: {epoch tag, prefix count}; tag 0 never matches a live epoch
  typedef struct packed {
    logic [EPOCH_W-1:0] tag;
    logic [CNT_W-1:0]   cnt;
  } entry_t;

  typedef struct packed {
    logic              en;
    logic              we;
    logic [MASK_W-1:0] addr;
    entry_t            wdata;
  } ram_req_t;

  typedef struct packed {
    logic             vld;
    logic [CNT_W-1:0] best;
    logic             ovf;
  } res_t;

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_PROBE = 5'b00100,
    S_WRITE = 5'b01000,
    S_OUT   = 5'b10000
  } state_t;

endpackage

>>> hw/rtl/longest_palindromic_anagram_run_unit.sv
// ----------------------------------------------------------------------------
// longest_palindromic_anagram_run_unit
// Longest run of a digit string that can be rearranged into a palindrome.
// ----------------------------------------------------------------------------
// Input channel (in_*): one decimal digit per item in in_tdata, in_tuser set
// on the first digit of a new string. Digits 10..15 are ignored.
// Result channel (out_*): one item per input item, the best run length so
// far in out_tdata and the overflow flag in out_tuser.
// A counted digit goes from acceptance to the result register in steps: an
// accept step, eleven reads of the single-port first-seen table (own mask
// and ten neighbours), a write step that stores the own mask if it is new,
// and a hand-off step. An ignored digit (out of range, or any digit once the
// string has overflowed) skips the table: accept and hand-off only.
// The next item is accepted only once the result is handed to the output
// register, so a counted digit is fully processed before the next item is
// taken, and a stall on out_tready holds the next item back.
// Table entries carry an epoch tag, so a new string needs no table clear,
// except every 255th start, which adds a clearing pass over the whole table.
// After reset the block runs the same clearing pass with in_tready low.
// When the receiver stalls, the result is held in the output register and
// the core waits with the next result; no item is lost.
// ----------------------------------------------------------------------------
module longest_palindromic_anagram_run_unit
  import lpar_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [3:0] digit, [7:4] zero
  input  logic        in_tuser,   // [0] start_req
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [15:0] best_len
  output logic        out_tuser   // [0] too_long
);

  ram_req_t         ram_req;
  entry_t           ram_rdata;
  res_t             res;
  logic             res_rdy;
  logic             out_vld_r, out_vld_nxt;
  logic [CNT_W-1:0] out_best_r;
  logic             out_ovf_r;

  lpar_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_vld    (in_tvalid),
    .in_rdy    (in_tready),
    .in_digit  (in_tdata[DIGIT_W-1:0]),
    .in_start  (in_tuser),
    .ram_req   (ram_req),
    .ram_rdata (ram_rdata),
    .res       (res),
    .res_rdy   (res_rdy)
  );

  lpar_ram #(
    .AW (MASK_W),
    .DW (ENT_W)
  ) u_ram (
    .clk   (clk),
    .en    (ram_req.en),
    .we    (ram_req.we),
    .addr  (ram_req.addr),
    .wdata (ram_req.wdata),
    .rdata (ram_rdata)
  );

  assign res_rdy = !out_vld_r || out_tready;

  always_comb begin
    out_vld_nxt = out_vld_r;
    if (res.vld && res_rdy) begin
      out_vld_nxt = 1'b1;
    end else if (out_tready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res.vld && res_rdy) begin
      out_best_r <= res.best;
      out_ovf_r  <= res.ovf;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_best_r;
  assign out_tuser  = out_ovf_r;

endmodule

>>> hw/rtl/lpar_ram.sv
// ----------------------------------------------------------------------------
// lpar_ram
// Single-port synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module lpar_ram #(
  parameter int AW = 10,
  parameter int DW = 24
) (
  input  logic          clk,
  input  logic          en,
  input  logic          we,
  input  logic [AW-1:0] addr,
  input  logic [DW-1:0] wdata,
  output logic [DW-1:0] rdata
);

  localparam int DEPTH = 1 << AW;

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> hw/rtl/lpar_core.sv
// ----------------------------------------------------------------------------
// lpar_core
// Sequencer: per counted digit, eleven table probes, one conditional write.
// ----------------------------------------------------------------------------
module lpar_core
  import lpar_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_vld,
  output logic               in_rdy,
  input  logic [DIGIT_W-1:0] in_digit,
  input  logic               in_start,
  output ram_req_t           ram_req,
  input  entry_t             ram_rdata,
  output res_t               res,
  input  logic               res_rdy
);

  state_t             state_r, state_nxt;
  logic [EPOCH_W-1:0] epoch_r, epoch_nxt;
  logic [MASK_W-1:0]  clr_addr_r, clr_addr_nxt;
  logic [MASK_W-1:0]  mask_r, mask_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [CNT_W-1:0]   best_r, best_nxt;
  logic               ovf_r, ovf_nxt;
  logic               go_r, go_nxt;
  logic               item_r, item_nxt;
  logic [PIDX_W-1:0]  pidx_r, pidx_nxt;
  logic               ev_vld_r, ev_vld_nxt;
  logic               ev_first_r, ev_first_nxt;
  logic               ev_zero_r, ev_zero_nxt;
  logic               self_new_r, self_new_nxt;

  logic [MASK_W-1:0]  base_mask;
  logic [CNT_W-1:0]   base_cnt;
  logic [CNT_W-1:0]   base_best;
  logic               base_ovf;
  logic               proc;
  logic [MASK_W-1:0]  key;
  logic               hit;
  logic [CNT_W-1:0]   at;
  logic [CNT_W-1:0]   span;

  assign in_rdy = (state_r == S_IDLE);

  // probe keys: own mask first, then each one-bit neighbour
  always_comb begin
    if (pidx_r == '0) begin
      key = mask_r;
    end else begin
      key = mask_r ^ (MASK_W'(1) << (pidx_r - PIDX_W'(1)));
    end
  end

  // mask zero is always present at count zero and never stored
  assign hit  = ev_zero_r || (ram_rdata.tag == epoch_r);
  assign at   = ev_zero_r ? '0 : ram_rdata.cnt;
  assign span = cnt_r - at;

  always_comb begin
    base_mask = in_start ? '0 : mask_r;
    base_cnt  = in_start ? '0 : cnt_r;
    base_best = in_start ? '0 : best_r;
    base_ovf  = in_start ? 1'b0 : ovf_r;
    proc      = !base_ovf && (in_digit < DIGIT_W'(NUM_SYMBOLS));
  end

  always_comb begin
    state_nxt    = state_r;
    epoch_nxt    = epoch_r;
    clr_addr_nxt = clr_addr_r;
    mask_nxt     = mask_r;
    cnt_nxt      = cnt_r;
    best_nxt     = best_r;
    ovf_nxt      = ovf_r;
    go_nxt       = go_r;
    item_nxt     = item_r;
    pidx_nxt     = pidx_r;
    ev_vld_nxt   = 1'b0;
    ev_first_nxt = 1'b0;
    ev_zero_nxt  = 1'b0;
    self_new_nxt = self_new_r;
    ram_req      = '0;
    res          = '0;

    if (ev_vld_r && hit && (span > best_r)) begin
      best_nxt = span;
    end
    if (ev_vld_r && ev_first_r) begin
      self_new_nxt = !hit;
    end

    case (state_r)
      S_CLEAR: begin
        ram_req.en    = 1'b1;
        ram_req.we    = 1'b1;
        ram_req.addr  = clr_addr_r;
        ram_req.wdata = '0;
        clr_addr_nxt  = clr_addr_r + MASK_W'(1);
        if (clr_addr_r == {MASK_W{1'b1}}) begin
          pidx_nxt = '0;
          if (!item_r) begin
            state_nxt = S_IDLE;
          end else if (go_r) begin
            state_nxt = S_PROBE;
          end else begin
            state_nxt = S_OUT;
          end
        end
      end
      S_IDLE: begin
        if (in_vld) begin
          mask_nxt = base_mask;
          cnt_nxt  = base_cnt;
          best_nxt = base_best;
          ovf_nxt  = base_ovf;
          go_nxt   = 1'b0;
          item_nxt = 1'b1;
          pidx_nxt = '0;
          if (proc) begin
            if (32'(base_cnt) >= 32'(MAX_LEN)) begin
              ovf_nxt = 1'b1;
            end else begin
              go_nxt   = 1'b1;
              mask_nxt = base_mask ^ (MASK_W'(1) << in_digit);
              cnt_nxt  = base_cnt + CNT_W'(1);
            end
          end
          // a wrapped epoch could alias stale entries: sweep first
          if (in_start && (epoch_r == EPOCH_LAST)) begin
            epoch_nxt    = EPOCH_FIRST;
            clr_addr_nxt = '0;
            state_nxt    = S_CLEAR;
          end else begin
            if (in_start) begin
              epoch_nxt = epoch_r + EPOCH_W'(1);
            end
            state_nxt = (proc && !(32'(base_cnt) >= 32'(MAX_LEN))) ? S_PROBE : S_OUT;
          end
        end
      end
      S_PROBE: begin
        ram_req.en   = 1'b1;
        ram_req.addr = key;
        ev_vld_nxt   = 1'b1;
        ev_first_nxt = (pidx_r == '0);
        ev_zero_nxt  = (key == '0);
        pidx_nxt     = pidx_r + PIDX_W'(1);
        if (pidx_r == PIDX_W'(PROBE_N - 1)) begin
          state_nxt = S_WRITE;
        end
      end
      S_WRITE: begin
        if (self_new_r) begin
          ram_req.en        = 1'b1;
          ram_req.we        = 1'b1;
          ram_req.addr      = mask_r;
          ram_req.wdata.tag = epoch_r;
          ram_req.wdata.cnt = cnt_r;
        end
        state_nxt = S_OUT;
      end
      S_OUT: begin
        res.vld  = 1'b1;
        res.best = best_r;
        res.ovf  = ovf_r;
        if (res_rdy) begin
          item_nxt  = 1'b0;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_CLEAR;
      epoch_r    <= EPOCH_FIRST;
      clr_addr_r <= '0;
      mask_r     <= '0;
      cnt_r      <= '0;
      best_r     <= '0;
      ovf_r      <= 1'b0;
      go_r       <= 1'b0;
      item_r     <= 1'b0;
      pidx_r     <= '0;
      ev_vld_r   <= 1'b0;
      ev_first_r <= 1'b0;
      ev_zero_r  <= 1'b0;
      self_new_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      epoch_r    <= epoch_nxt;
      clr_addr_r <= clr_addr_nxt;
      mask_r     <= mask_nxt;
      cnt_r      <= cnt_nxt;
      best_r     <= best_nxt;
      ovf_r      <= ovf_nxt;
      go_r       <= go_nxt;
      item_r     <= item_nxt;
      pidx_r     <= pidx_nxt;
      ev_vld_r   <= ev_vld_nxt;
      ev_first_r <= ev_first_nxt;
      ev_zero_r  <= ev_zero_nxt;
      self_new_r <= self_new_nxt;
    end
  end

endmodule
